FILE: hw/rtl/stms_pkg.sv
// Shared types, constants and angle table for the seek target motion step block.
`timescale 1ns / 1ps
package stms_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_GOAL  = 2'd1;
   localparam logic [1:0] KIND_PLACE = 2'd2;

   localparam int ITER_W   = 5;
   localparam int DIV_BITS = 24;
   localparam int CX_W     = 53;
   localparam int ANG_W    = 34;
   localparam int DIST_W   = 54;
   localparam int REM_W    = DIST_W + 1;

   localparam logic [31:0] INVK = 32'h9B74EDA8;
   localparam logic signed [32:0] ALT_SLEW = 33'sd13107;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sh080000000;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh040000000;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_DIFF,
      CMD_SQ_X,
      CMD_SQ_Z,
      CMD_SQ_T,
      CMD_ARRIVE,
      CMD_CORDIC_INIT,
      CMD_CORDIC_STEP,
      CMD_MUL_HI,
      CMD_MUL_LO,
      CMD_DIST,
      CMD_MUL_SX,
      CMD_DIV_X,
      CMD_DIV_Z,
      CMD_DIV_STEP,
      CMD_FINISH,
      CMD_RESULT
   } cmd_type;

   typedef struct packed {
      logic done;
      logic both_zero;
      logic near;
      logic sq_less;
      logic exact;
      logic rot_last;
      logic div_last;
      logic full_step;
   } stat_type;

   function automatic logic [29:0] atan_lut(input logic [ITER_W-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         5'd20: v = 30'h0000028C;
         5'd21: v = 30'h00000146;
         5'd22: v = 30'h000000A3;
         5'd23: v = 30'h00000051;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/stms_datapath.sv
// Datapath: motion state, shared multiplier, CORDIC, two-lane divider and result register.
`timescale 1ns / 1ps
module stms_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  stms_pkg::cmd_type  cmd,
   output stms_pkg::stat_type stat,
   input  logic [1:0]         req_kind,
   input  logic [95:0]        req_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   output logic [111:0]       rsp_data,
   output logic               rsp_arrived
);
   import stms_pkg::*;

   logic [15:0] speed_ff, tol_ff;
   logic [31:0] hx_ff, hz_ff, hh_ff, gx_ff, gz_ff, gh_ff;
   logic [15:0] facing_ff;
   logic        done_ff;

   logic signed [32:0] dx_ff, dz_ff;
   logic signed [CX_W-1:0] cx_ff, cy_ff;
   logic signed [ANG_W-1:0] ang_ff;
   logic [ITER_W-1:0] it_ff;
   logic [64:0] mul_ff;
   logic [34:0] acc_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [REM_W-1:0] remx_ff, remz_ff;
   logic [DIV_BITS-1:0] nlox_ff, nloz_ff, qx_ff, qz_ff;
   logic [111:0] rsp_data_ff;
   logic         rsp_arr_ff;

   logic [32:0] adx, adz;
   logic [16:0] thr;
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] mul_in;
   logic signed [CX_W-1:0] xsh, ysh;
   logic signed [ANG_W-1:0] atan_v;
   logic [REM_W-1:0] r2x, r2z;
   logic gex, gez;
   logic signed [33:0] dx34, dz34, xv, yv;
   logic signed [32:0] stepx, stepz, hm, hp;
   logic [31:0] h_in;
   logic [ANG_W-1:0] ang_mag;
   logic [17:0] ang_t;
   logic [15:0] head_in;

   assign adx = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign adz = dz_ff[32] ? 33'(-dz_ff) : 33'(dz_ff);
   assign thr = 17'(speed_ff) + 17'(tol_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd)
         CMD_SQ_X: begin
            mul_a = adx;
            mul_b = 32'(adx[16:0]);
         end
         CMD_SQ_Z: begin
            mul_a = adz;
            mul_b = 32'(adz[16:0]);
         end
         CMD_SQ_T: begin
            mul_a = 33'(thr);
            mul_b = 32'(thr);
         end
         CMD_MUL_HI: begin
            mul_a = 33'(cx_ff[CX_W-1:32]);
            mul_b = INVK;
         end
         CMD_MUL_LO: begin
            mul_a = 33'(cx_ff[31:0]);
            mul_b = INVK;
         end
         CMD_MUL_SX: begin
            mul_a = adx;
            mul_b = 32'(speed_ff);
         end
         CMD_DIV_X: begin
            mul_a = adz;
            mul_b = 32'(speed_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_in = 65'(mul_a) * 65'(mul_b);

   assign dx34 = 34'(dx_ff);
   assign dz34 = 34'(dz_ff);
   assign xv = dz_ff[32] ? -dz34 : dz34;
   assign yv = dz_ff[32] ? -dx34 : dx34;
   assign xsh = cx_ff >>> it_ff;
   assign ysh = cy_ff >>> it_ff;
   assign atan_v = $signed({4'b0, atan_lut(it_ff)});

   assign r2x = {remx_ff[REM_W-2:0], nlox_ff[DIV_BITS-1]};
   assign r2z = {remz_ff[REM_W-2:0], nloz_ff[DIV_BITS-1]};
   assign gex = r2x >= REM_W'(dist_ff);
   assign gez = r2z >= REM_W'(dist_ff);

   assign stepx = stat.full_step ? dx_ff :
                  (dx_ff[32] ? -$signed(33'(qx_ff)) : $signed(33'(qx_ff)));
   assign stepz = stat.full_step ? dz_ff :
                  (dz_ff[32] ? -$signed(33'(qz_ff)) : $signed(33'(qz_ff)));

   assign hm = $signed(33'(signed'(hh_ff))) - ALT_SLEW;
   assign hp = $signed(33'(signed'(hh_ff))) + ALT_SLEW;
   always_comb begin
      if (signed'(hh_ff) > signed'(gh_ff)) begin
         h_in = (hm < $signed(33'(signed'(gh_ff)))) ? gh_ff : hm[31:0];
      end else if (signed'(hh_ff) < signed'(gh_ff)) begin
         h_in = (hp > $signed(33'(signed'(gh_ff)))) ? gh_ff : hp[31:0];
      end else begin
         h_in = hh_ff;
      end
   end

   assign ang_mag = ang_ff[ANG_W-1] ? ANG_W'(-ang_ff) : ANG_W'(ang_ff);
   assign ang_t = ang_mag[ANG_W-1:16];
   assign head_in = ang_ff[ANG_W-1] ? 16'(-ang_t) : ang_t[15:0];

   assign stat.done      = done_ff;
   assign stat.both_zero = (adx == '0) && (adz == '0);
   assign stat.near      = (adx < 33'(thr)) && (adz < 33'(thr));
   assign stat.sq_less   = acc_ff < mul_ff[34:0];
   assign stat.exact     = (dx_ff == '0) || (dz_ff == '0);
   assign stat.rot_last  = it_ff == ITER_W'(CORDIC_STEPS - 1);
   assign stat.div_last  = it_ff == ITER_W'(DIV_BITS - 1);
   assign stat.full_step = (dist_ff == '0) || (DIST_W'({speed_ff, 16'b0}) >= dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= '0;
         tol_ff    <= '0;
         hx_ff     <= '0;
         hz_ff     <= '0;
         hh_ff     <= '0;
         gx_ff     <= '0;
         gz_ff     <= '0;
         gh_ff     <= '0;
         facing_ff <= '0;
         done_ff   <= 1'b1;
      end else begin
         if (csr_we) begin
            if (csr_index) tol_ff <= csr_wdata;
            else speed_ff <= csr_wdata;
         end
         case (cmd)
            CMD_ACCEPT: begin
               if (req_kind == KIND_GOAL) begin
                  gx_ff   <= req_data[31:0];
                  gz_ff   <= req_data[63:32];
                  gh_ff   <= req_data[95:64];
                  done_ff <= 1'b0;
               end else if (req_kind == KIND_PLACE) begin
                  hx_ff <= req_data[31:0];
                  hz_ff <= req_data[63:32];
                  hh_ff <= req_data[95:64];
               end
            end
            CMD_ARRIVE: done_ff <= 1'b1;
            CMD_FINISH: begin
               hx_ff     <= hx_ff + stepx[31:0];
               hz_ff     <= hz_ff + stepz[31:0];
               hh_ff     <= h_in;
               facing_ff <= head_in;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      case (cmd)
         CMD_DIFF: begin
            dx_ff <= $signed(33'(signed'(gx_ff))) - $signed(33'(signed'(hx_ff)));
            dz_ff <= $signed(33'(signed'(gz_ff))) - $signed(33'(signed'(hz_ff)));
         end
         CMD_SQ_Z: acc_ff <= mul_ff[34:0];
         CMD_SQ_T: acc_ff <= acc_ff + mul_ff[34:0];
         CMD_CORDIC_INIT: begin
            it_ff <= '0;
            if (dx_ff == '0) begin
               ang_ff  <= (dz_ff > 0) ? '0 : HALF_TURN;
               dist_ff <= DIST_W'({adz, 16'b0});
            end else if (dz_ff == '0) begin
               ang_ff  <= (dx_ff > 0) ? QUARTER_TURN : -QUARTER_TURN;
               dist_ff <= DIST_W'({adx, 16'b0});
            end else begin
               cx_ff  <= CX_W'(xv) <<< 16;
               cy_ff  <= CX_W'(yv) <<< 16;
               ang_ff <= dz_ff[32] ? ((dx_ff > 0) ? HALF_TURN : -HALF_TURN) : '0;
            end
         end
         CMD_CORDIC_STEP: begin
            it_ff <= it_ff + 1'b1;
            if (cy_ff > 0) begin
               cx_ff  <= cx_ff + ysh;
               cy_ff  <= cy_ff - xsh;
               ang_ff <= ang_ff + atan_v;
            end else begin
               cx_ff  <= cx_ff - ysh;
               cy_ff  <= cy_ff + xsh;
               ang_ff <= ang_ff - atan_v;
            end
         end
         CMD_MUL_LO: dist_ff <= mul_ff[DIST_W-1:0];
         CMD_DIST: dist_ff <= dist_ff + DIST_W'(mul_ff[63:32]);
         CMD_DIV_X: begin
            remx_ff <= REM_W'(mul_ff[48:8]);
            nlox_ff <= {mul_ff[7:0], 16'b0};
         end
         CMD_DIV_Z: begin
            remz_ff <= REM_W'(mul_ff[48:8]);
            nloz_ff <= {mul_ff[7:0], 16'b0};
            it_ff   <= '0;
         end
         CMD_DIV_STEP: begin
            it_ff   <= it_ff + 1'b1;
            nlox_ff <= nlox_ff << 1;
            nloz_ff <= nloz_ff << 1;
            remx_ff <= gex ? (r2x - REM_W'(dist_ff)) : r2x;
            remz_ff <= gez ? (r2z - REM_W'(dist_ff)) : r2z;
            qx_ff   <= {qx_ff[DIV_BITS-2:0], gex};
            qz_ff   <= {qz_ff[DIV_BITS-2:0], gez};
         end
         CMD_RESULT: begin
            rsp_data_ff <= {facing_ff, hh_ff, hz_ff, hx_ff};
            rsp_arr_ff  <= done_ff;
         end
         default: ;
      endcase
   end

   assign rsp_data    = rsp_data_ff;
   assign rsp_arrived = rsp_arr_ff;

endmodule

FILE: hw/rtl/stms_ctrl.sv
// Controller: sequences one item through arrival test, CORDIC, divide and update.
`timescale 1ns / 1ps
module stms_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_kind,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output stms_pkg::cmd_type  cmd,
   input  stms_pkg::stat_type stat
);
   import stms_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_SQX, S_SQZ, S_SQT, S_CMP, S_ARRIVE, S_PRE, S_ROT,
      S_MHI, S_MLO, S_DIST, S_SPD, S_DIVX, S_DIVZ, S_DIV, S_FINISH, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      accept, out_free;

   assign accept     = req_tvalid && (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd      = CMD_ACCEPT;
               state_in = (req_kind == KIND_TICK && !stat.done) ? S_DIFF : S_RESULT;
            end
         end
         S_DIFF: begin
            cmd      = CMD_DIFF;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd = CMD_SQ_X;
            if (stat.both_zero) state_in = S_ARRIVE;
            else if (!stat.near) state_in = S_PRE;
            else state_in = S_SQZ;
         end
         S_SQZ: begin
            cmd      = CMD_SQ_Z;
            state_in = S_SQT;
         end
         S_SQT: begin
            cmd      = CMD_SQ_T;
            state_in = S_CMP;
         end
         S_CMP: state_in = stat.sq_less ? S_ARRIVE : S_PRE;
         S_ARRIVE: begin
            cmd      = CMD_ARRIVE;
            state_in = S_RESULT;
         end
         S_PRE: begin
            cmd      = CMD_CORDIC_INIT;
            state_in = stat.exact ? S_SPD : S_ROT;
         end
         S_ROT: begin
            cmd = CMD_CORDIC_STEP;
            if (stat.rot_last) state_in = S_MHI;
         end
         S_MHI: begin
            cmd      = CMD_MUL_HI;
            state_in = S_MLO;
         end
         S_MLO: begin
            cmd      = CMD_MUL_LO;
            state_in = S_DIST;
         end
         S_DIST: begin
            cmd      = CMD_DIST;
            state_in = S_SPD;
         end
         S_SPD: begin
            if (stat.full_step) begin
               state_in = S_FINISH;
            end else begin
               cmd      = CMD_MUL_SX;
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            cmd      = CMD_DIV_X;
            state_in = S_DIVZ;
         end
         S_DIVZ: begin
            cmd      = CMD_DIV_Z;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd = CMD_DIV_STEP;
            if (stat.div_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd      = CMD_FINISH;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               cmd      = CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_RESULT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted transfer did not start work");
   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not presented");
   a_arrive_sets_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ARRIVE |=> stat.done)
      else $error("arrival did not set done");
   a_rot_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT && stat.rot_last) |=> state_ff == S_MHI)
      else $error("rotation count overrun");
`endif

endmodule

FILE: hw/rtl/seek_target_motion_step.sv
// Top level of the seek target motion step block.
`timescale 1ns / 1ps
// Usage:
//   req channel: one transfer per item; tuser carries the kind (tick, set goal,
//   place), tdata carries x, z and height. rsp channel: one transfer per item
//   with the position, altitude and heading after that item; tuser is arrived.
//   csr port: csr_we with csr_index 0 writes speed_limit, 1 arrive_tolerance.
//   Paths: goal, place, unused kinds and ticks while arrived go from the transfer
//   straight to the result register. A tick that arrives passes the arrival test
//   first; an axis aligned step skips the CORDIC; a general step runs the CORDIC
//   and its gain correction, and either step runs the divider unless the full
//   step is taken. Work runs through the CORDIC iterations and a bit-serial
//   divider with a 24-bit quotient; the gain correction and the divider
//   operands use one shared 33 x 32 multiplier datapath.
//   One item is in work at a time; req_tready is high only while idle.
//   The result sits in an output register; a new item is taken while it waits,
//   and a further result holds until rsp_tready frees that register.
//   Reset: synchronous, active high; position, goal and heading clear,
//   the point counts as arrived and both registers clear to zero.
module seek_target_motion_step #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // pos_x, pos_z, height
   input  logic [1:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,  // cur_x, cur_z, cur_height, heading
   output logic [0:0]   rsp_tuser,  // arrived
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import stms_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     arrived;

   stms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   stms_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_kind    (req_tuser),
      .req_data    (req_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index[0]),
      .csr_wdata   (csr_wdata),
      .rsp_data    (rsp_tdata),
      .rsp_arrived (arrived)
   );

   assign rsp_tuser = arrived;

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the seek target motion step block: fixed-point predictor and streaming checks.
`timescale 1ns / 1ps
module testbench;
   import stms_pkg::*;

   localparam int STEPS = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [0:0] REG_SPEED = 1'b0;
   localparam logic [0:0] REG_TOL = 1'b1;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] z;
      logic [31:0] h;
      logic [15:0] head;
      logic        arrived;
   } pose_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [1:0]   req_tuser = KIND_TICK;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [0:0]   csr_index = REG_SPEED;
   logic [15:0]  csr_wdata = '0;

   seek_target_motion_step #(.CORDIC_STEPS(STEPS)) i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint unsigned speed, tol;
   logic signed [31:0] hx, hz, hh, gx, gz, gh;
   logic [15:0] face;
   bit done;
   pose_type pose_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stall_random = 1'b1;

   const longint atan_step[24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint unsigned step_div(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   task automatic advance_motion();
      longint dx, dz, ang, x, y, nx, ny, sxs, szs, h, g;
      longint unsigned adx, adz, thr, dist_q, spd, ux;
      dx = longint'(gx) - longint'(hx);
      dz = longint'(gz) - longint'(hz);
      adx = dx < 0 ? -dx : dx;
      adz = dz < 0 ? -dz : dz;
      thr = speed + tol;
      if (adx == 0 && adz == 0) begin
         done = 1'b1;
         return;
      end
      if (adx < thr && adz < thr && adx * adx + adz * adz < thr * thr) begin
         done = 1'b1;
         return;
      end
      if (dx == 0) begin
         ang = dz > 0 ? 0 : 64'sh80000000;
         dist_q = adz << 16;
      end else if (dz == 0) begin
         ang = dx > 0 ? 64'sh40000000 : -64'sh40000000;
         dist_q = adx << 16;
      end else begin
         x = dz;
         y = dx;
         ang = 0;
         if (x < 0) begin
            ang = y > 0 ? 64'sh80000000 : -64'sh80000000;
            x = -x;
            y = -y;
         end
         x = x * 65536;
         y = y * 65536;
         for (int i = 0; i < STEPS && i < 24; i++) begin
            if (y > 0) begin
               nx = x + floor_shift(y, i);
               ny = y - floor_shift(x, i);
               ang += atan_step[i];
            end else begin
               nx = x - floor_shift(y, i);
               ny = y + floor_shift(x, i);
               ang -= atan_step[i];
            end
            x = nx;
            y = ny;
         end
         ux = x;
         dist_q = (ux >> 32) * 64'h9B74EDA8 + (((ux & 64'hFFFFFFFF) * 64'h9B74EDA8) >> 32);
      end
      spd = speed << 16;
      if (dist_q == 0 || spd >= dist_q) begin
         sxs = dx;
         szs = dz;
      end else begin
         sxs = step_div(adx * speed, dist_q);
         szs = step_div(adz * speed, dist_q);
         if (dx < 0) sxs = -sxs;
         if (dz < 0) szs = -szs;
      end
      ang = ang >= 0 ? (ang >> 16) : -((-ang) >> 16);
      face = ang[15:0];
      h = hh;
      g = gh;
      if (h > g) begin
         h -= 13107;
         if (h < g) h = g;
      end else if (h < g) begin
         h += 13107;
         if (h > g) h = g;
      end
      hh = h[31:0];
      hx = 32'(longint'(hx) + sxs);
      hz = 32'(longint'(hz) + szs);
   endtask

   task automatic predict_item(logic [1:0] kind, logic [31:0] px, logic [31:0] pz,
                               logic [31:0] ph);
      pose_type p;
      case (kind)
         KIND_TICK: if (!done) advance_motion();
         KIND_GOAL: begin
            gx = px; gz = pz; gh = ph; done = 1'b0;
         end
         KIND_PLACE: begin
            hx = px; hz = pz; hh = ph;
         end
         default: ;
      endcase
      p.x = hx; p.z = hz; p.h = hh; p.head = face; p.arrived = done;
      pose_queue.push_back(p);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // checker
   always @(posedge clock) begin
      pose_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pose_queue.size() == 0) report("unexpected result", rsp_tdata[31:0], 0);
            else begin
               want = pose_queue.pop_front();
               if (rsp_tdata[31:0] !== want.x) report("cur_x", rsp_tdata[31:0], want.x);
               if (rsp_tdata[63:32] !== want.z) report("cur_z", rsp_tdata[63:32], want.z);
               if (rsp_tdata[95:64] !== want.h) report("cur_height", rsp_tdata[95:64], want.h);
               if (rsp_tdata[111:96] !== want.head)
                  report("heading", rsp_tdata[111:96], want.head);
               if (rsp_tuser[0] !== want.arrived)
                  report("arrived", rsp_tuser[0], want.arrived);
            end
         end
         rsp_tready <= stall_random ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   int burst_left = 0;

   task automatic send_item(logic [1:0] kind, logic [31:0] px, logic [31:0] pz,
                            logic [31:0] ph);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 1) ? $urandom_range(0, 60) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {ph, pz, px};
      do @(posedge clock); while (!req_tready);
      predict_item(kind, px, pz, ph);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_SPEED) speed = val;
      else tol = val;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int span);
      return $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 2 * span))
             - span);
   endfunction

   task automatic test_directed();
      write_reg(REG_SPEED, 16'd100);
      write_reg(REG_TOL, 16'd0);
      send_item(KIND_TICK, 0, 0, 0);
      send_item(KIND_GOAL, 0, 0, 0);
      send_item(KIND_TICK, 0, 0, 0);
      send_item(KIND_GOAL, 1000, 0, 32'sh00010000);
      repeat (3) send_item(KIND_TICK, 0, 0, 0);
      send_item(KIND_GOAL, 0, -1000, -32'sh00010000);
      repeat (2) send_item(KIND_TICK, 0, 0, 0);
      send_item(KIND_GOAL, -700, 300, 0);
      repeat (2) send_item(KIND_TICK, 0, 0, 0);
      send_item(KIND_PLACE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_item(KIND_GOAL, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      repeat (2) send_item(KIND_TICK, 0, 0, 0);
      send_item(KIND_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_item(KIND_PLACE, 0, 0, 0);
      send_item(KIND_GOAL, 150, 150, 5);
      repeat (4) send_item(KIND_TICK, 0, 0, 0);
      drain();
   endtask

   task automatic test_speed_extremes();
      write_reg(REG_SPEED, 16'd0);
      write_reg(REG_TOL, 16'hFFFF);
      send_item(KIND_GOAL, 32'h00100000, 32'hFFF00000, 32'h00100000);
      repeat (3) send_item(KIND_TICK, 0, 0, 0);
      drain();
      write_reg(REG_TOL, 16'd0);
      repeat (3) send_item(KIND_TICK, 0, 0, 0);
      drain();
      write_reg(REG_SPEED, 16'hFFFF);
      send_item(KIND_GOAL, 32'h40000000, 32'hC0000000, 0);
      repeat (6) send_item(KIND_TICK, 0, 0, 0);
      drain();
   endtask

   task automatic test_random_runs(int count);
      int sent = 0;
      int span;
      logic [1:0] kind;
      while (sent < count) begin
         write_reg(REG_SPEED, 16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 400)));
         write_reg(REG_TOL, 16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 50)));
         stall_random = $urandom_range(0, 3) != 0;
         repeat (10) begin
            span = $urandom_range(0, 1) ? 5000 : 100;
            if ($urandom_range(0, 2) == 0) begin
               send_item(KIND_PLACE, rand_coord(span), rand_coord(span), $urandom());
               sent++;
            end
            send_item(KIND_GOAL, rand_coord(span), rand_coord(span), $urandom());
            sent++;
            repeat ($urandom_range(1, 8)) begin
               kind = $urandom_range(0, 9) == 0 ? 2'($urandom_range(0, 3)) : KIND_TICK;
               send_item(kind, $urandom(), $urandom(), $urandom());
               sent++;
            end
         end
         drain();
      end
   endtask

   initial begin
      speed = 0; tol = 0; hx = 0; hz = 0; hh = 0; gx = 0; gz = 0; gh = 0;
      face = 0; done = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_speed_extremes();
      test_random_runs(620);
      drain();
      if (errors == 0 && pose_queue.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

FILE: seek_target_motion_step.f
hw/rtl/stms_pkg.sv
hw/rtl/stms_datapath.sv
hw/rtl/stms_ctrl.sv
hw/rtl/seek_target_motion_step.sv
tb/sv/testbench.sv
